/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the stream word masker.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WORD_DEF = 8;
  localparam int JOB_BYTES    = 8;
  localparam int CNT_W        = 4;
  localparam int IDX_W        = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int WLEN_W       = 4;

  localparam logic [7:0] MASK_CHAR = 8'h2A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_BYTES  = 2'd0,
    CFG_WORD_LENGTH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                   mask;
    logic [JOB_BYTES*8-1:0] bytes;
    logic [CNT_W-1:0]       count;
    logic                   stream_end;
  } swm_job_t;

endpackage

/* rtl/core/swm_text_if.sv */
// ----------------------------------------------------------------------------
// swm_text_if
// Input byte stream channel.
// ----------------------------------------------------------------------------
interface swm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_stream_end;

  modport source (output valid, output in_byte, output in_stream_end, input ready);
  modport sink   (input valid, input in_byte, input in_stream_end, output ready);
endinterface

/* rtl/core/swm_result_if.sv */
// ----------------------------------------------------------------------------
// swm_result_if
// Output byte stream channel.
// ----------------------------------------------------------------------------
interface swm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       out_stream_end;

  modport source (output valid, output out_byte, output run_end, output out_stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input out_stream_end,
                  output ready);
endinterface

/* rtl/core/swm_cfg_if.sv */
// ----------------------------------------------------------------------------
// swm_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface swm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/swm_front.sv */
// ----------------------------------------------------------------------------
// swm_front
// Holds the config registers and the window, matches each byte and
// issues at most one output job per request.
// ----------------------------------------------------------------------------
module swm_front #(
  parameter int MAX_WORD = swm_pkg::MAX_WORD_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [swm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    in_byte,
  input  logic                          in_stream_end,
  output logic                          job_valid,
  output swm_pkg::swm_job_t             job
);
  import swm_pkg::*;

  localparam int LEN_W = $clog2(MAX_WORD + 1);

  logic [CFG_DATA_W-1:0] word;
  logic [WLEN_W-1:0]     wlen;
  logic [LEN_W-1:0]      fill;
  logic [LEN_W-1:0]      fill_next;
  logic [7:0]            window [MAX_WORD];
  logic [7:0]            cand   [MAX_WORD];
  logic [WLEN_W-1:0]     wl_clip;
  logic [LEN_W-1:0]      len;
  logic                  full;
  logic                  match;
  logic                  shift;

  always_comb begin
    if (wlen == '0) begin
      wl_clip = WLEN_W'(1);
    end else if (wlen > WLEN_W'(MAX_WORD)) begin
      wl_clip = WLEN_W'(MAX_WORD);
    end else begin
      wl_clip = wlen;
    end
  end

  assign len  = wl_clip[LEN_W-1:0];
  assign full = (fill + LEN_W'(1)) == len;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_WORD; i++) begin
      cand[i] = (LEN_W'(i) == fill) ? in_byte : window[i];
      if ((LEN_W'(i) < len) && (cand[i] != word[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign shift = full && !match;

  always_comb begin
    job            = '0;
    job.stream_end = in_stream_end;
    for (int i = 0; i < MAX_WORD; i++) begin
      job.bytes[8*i +: 8] = cand[i];
    end
    if (full && match) begin
      job.mask  = 1'b1;
      job.count = CNT_W'(len);
      fill_next = '0;
    end else if (full) begin
      job.count = in_stream_end ? CNT_W'(len) : CNT_W'(1);
      fill_next = in_stream_end ? '0 : len - LEN_W'(1);
    end else begin
      job.count = in_stream_end ? CNT_W'(fill + LEN_W'(1)) : '0;
      fill_next = in_stream_end ? '0 : fill + LEN_W'(1);
    end
  end

  assign job_valid = accept && (job.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
      wlen <= WLEN_W'(1);
      fill <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WORD_BYTES:  word <= cfg_data;
        CFG_WORD_LENGTH: begin
          wlen <= cfg_data[WLEN_W-1:0];
          fill <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_WORD - 1; i++) begin
        window[i] <= shift ? cand[i+1] : cand[i];
      end
      window[MAX_WORD-1] <= cand[MAX_WORD-1];
    end
  end

endmodule

/* rtl/core/swm_queue.sv */
// ----------------------------------------------------------------------------
// swm_queue
// Short job FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module swm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swm_pkg::swm_job_t push_job,
  output logic              not_full,
  input  logic              pop,
  output logic              head_valid,
  output swm_pkg::swm_job_t head_job
);
  import swm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

  swm_job_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_Q-1:0] used;

  assign not_full   = used != CNT_Q'(QUEUE_DEPTH);
  assign head_valid = used != '0;
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        used <= used + CNT_Q'(1);
      end else if (pop && !push) begin
        used <= used - CNT_Q'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

/* rtl/core/swm_back.sv */
// ----------------------------------------------------------------------------
// swm_back
// Plays out one job as a run of result bytes, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module swm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  swm_pkg::swm_job_t head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              run_end,
  output logic              out_stream_end
);
  import swm_pkg::*;

  logic             busy;
  swm_job_t         cur;
  logic [IDX_W-1:0] idx;
  logic             fire;

  assign out_valid      = busy;
  assign out_byte       = cur.mask ? MASK_CHAR : cur.bytes[8*idx +: 8];
  assign run_end        = (CNT_W'(idx) + CNT_W'(1)) == cur.count;
  assign out_stream_end = run_end && cur.stream_end;
  assign fire           = busy && out_ready;
  assign pop            = head_valid && (!busy || (fire && run_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (!busy || (fire && run_end)) begin
      busy <= head_valid;
      idx  <= '0;
    end else if (fire) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

endmodule

/* rtl/core/stream_word_masker_unit.sv */
// ----------------------------------------------------------------------------
// stream_word_masker_unit
// Sliding-window word censor for a byte stream.
//
// text_ch carries one byte per request with a stream-end flag. Each byte
// yields zero or more result bytes on result_ch: the oldest window byte, a
// run of '*' on a word match, or the flushed window on stream end. run_end
// marks the last result of one input request, out_stream_end the last
// result of the stream. cfg_ch writes the word (index 0) and its length
// (index 1); writing the length empties the window.
// A taken input's job is registered in the queue, then in the back part.
// Throughput: one input byte per cycle while each gives at most one result
// and result_ch is ready; a run of results holds the output side until it
// ends, and a two-entry job queue lets the input side keep going meanwhile.
// A stalled result_ch holds the current result; input stalls once the
// queue is full. Reset empties the window and queue, word 0, length 1.
// ----------------------------------------------------------------------------
module stream_word_masker_unit #(
  parameter int MAX_WORD = swm_pkg::MAX_WORD_DEF
) (
  input logic         clk,
  input logic         rst,
  swm_text_if.sink    text_ch,
  swm_result_if.source result_ch,
  swm_cfg_if.sink     cfg_ch
);
  import swm_pkg::*;

  logic     accept;
  logic     job_valid;
  swm_job_t job;
  logic     q_not_full;
  logic     pop;
  logic     head_valid;
  swm_job_t head_job;

  assign cfg_ch.ready  = 1'b1;
  assign text_ch.ready = q_not_full;
  assign accept        = text_ch.valid && q_not_full;

  swm_front #(
    .MAX_WORD(MAX_WORD)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .accept       (accept),
    .in_byte      (text_ch.in_byte),
    .in_stream_end(text_ch.in_stream_end),
    .job_valid    (job_valid),
    .job          (job)
  );

  swm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_valid),
    .push_job  (job),
    .not_full  (q_not_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  swm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .out_byte      (result_ch.out_byte),
    .run_end       (result_ch.run_end),
    .out_stream_end(result_ch.out_stream_end)
  );

endmodule
